// ----- hw/rtl/rfla_pkg.sv -----
package rfla_pkg;

  localparam int POOL_CHUNKS      = 64;
  localparam int MAX_CONNECTIONS  = 4;
  localparam int QUEUE_PRIORITIES = 4;

  localparam int IDX_W   = $clog2(POOL_CHUNKS);
  localparam int LINK_W  = $clog2(POOL_CHUNKS + 1);
  localparam int COUNT_W = $clog2(POOL_CHUNKS + 1);
  localparam int RES_W   = 13;

  localparam int OP_W     = 2;
  localparam int CHUNK_W  = 6;
  localparam int NEED_W   = 7;
  localparam int OPEN_W   = 3;
  localparam int FCOUNT_W = 7;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_CHUNKS);

  typedef struct packed {
    logic capture;
    logic execute;
  } rfla_cmd_t;

endpackage

// ----- hw/rtl/rfla_if.sv -----
interface rfla_req_if
  import rfla_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic                new_connection;
  logic                chunk_present;
  logic [CHUNK_W-1:0]  chunk_index;
  logic [NEED_W-1:0]   chunks_needed;
  logic [OPEN_W-1:0]   open_connections;

  modport source (
    output valid, op, new_connection, chunk_present, chunk_index, chunks_needed,
           open_connections,
    input  ready
  );
  modport sink (
    input  valid, op, new_connection, chunk_present, chunk_index, chunks_needed,
           open_connections,
    output ready
  );
endinterface

interface rfla_rsp_if
  import rfla_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                granted;
  logic [CHUNK_W-1:0]  granted_index;
  logic [FCOUNT_W-1:0] free_count;

  modport source (
    output valid, granted, granted_index, free_count,
    input  ready
  );
  modport sink (
    input  valid, granted, granted_index, free_count,
    output ready
  );
endinterface

// ----- hw/rtl/reserved_free_list_allocator.sv -----
// Free-list chunk allocator with a connection reserve.
//
// Requests arrive on req (valid/ready): op selects allocate, free or query,
// with the operands for each. Every request transaction yields exactly one
// response transaction on rsp: granted, the allocated chunk index and the
// number of free chunks left afterwards.
//
// A request passes a capture step and a decision step: capture reads the link of
// the head chunk from the synchronous link memory, the decision step decides,
// updates the list and loads the response register. No new request is taken
// while a decision is pending, so the block handles one request at a time.
// The response is driven from the response register.
//
// If the receiver stalls, the response waits in its register; one further
// request can be taken meanwhile and holds in its decision step until rsp is
// free. Reset empties the response register and returns the whole pool to the
// free list in order, with no clearing pass.
module reserved_free_list_allocator
  import rfla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rfla_req_if.sink   req,
  rfla_rsp_if.source rsp
);

  rfla_cmd_t cmd;

  rfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .cmd      (cmd)
  );

  rfla_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .op              (req.op),
    .new_connection  (req.new_connection),
    .chunk_present   (req.chunk_present),
    .chunk_index     (req.chunk_index),
    .chunks_needed   (req.chunks_needed),
    .open_connections(req.open_connections),
    .granted         (rsp.granted),
    .granted_index   (rsp.granted_index),
    .free_count      (rsp.free_count)
  );

endmodule

// ----- hw/rtl/rfla_ram.sv -----
module rfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rfla_ctrl.sv -----
module rfla_ctrl
  import rfla_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rfla_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/rfla_dp.sv -----
module rfla_dp
  import rfla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rfla_cmd_t           cmd,
  input  logic [OP_W-1:0]     op,
  input  logic                new_connection,
  input  logic                chunk_present,
  input  logic [CHUNK_W-1:0]  chunk_index,
  input  logic [NEED_W-1:0]   chunks_needed,
  input  logic [OPEN_W-1:0]   open_connections,
  output logic                granted,
  output logic [CHUNK_W-1:0]  granted_index,
  output logic [FCOUNT_W-1:0] free_count
);

  logic [OP_W-1:0]        op_r;
  logic                   newc_r;
  logic                   pres_r;
  logic [CHUNK_W-1:0]     idx_r;
  logic [NEED_W-1:0]      need_r;
  logic [OPEN_W-1:0]      open_r;

  logic [LINK_W-1:0]      head;
  logic [LINK_W-1:0]      head_next;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_next;
  logic [POOL_CHUNKS-1:0] vld;
  logic                   rd_vld;

  logic [LINK_W-1:0]      rdata;
  logic [LINK_W-1:0]      link;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [LINK_W-1:0]      wdata;

  logic [NEED_W-1:0]      need_eff;
  logic signed [RES_W-1:0] left;
  logic signed [RES_W-1:0] reserve;
  logic                   head_ok;
  logic                   grant_ok;
  logic                   free_ok;
  logic                   grant_next;
  logic [CHUNK_W-1:0]     gidx_next;

  rfla_ram #(
    .WIDTH(LINK_W),
    .DEPTH(POOL_CHUNKS)
  ) u_ram (
    .clk  (clk),
    .we   (we && cmd.execute),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.capture),
    .raddr(head[IDX_W-1:0]),
    .rdata(rdata)
  );

  // An entry never written reads as its reset link, which is its own index plus one.
  assign link = rd_vld ? rdata : head + LINK_W'(1);

  assign need_eff = (op_r == OP_ALLOC) ? NEED_W'(1) : need_r;
  assign left     = $signed(RES_W'(count)) - $signed(RES_W'(need_eff));
  assign reserve  = RES_W'(($signed(RES_W'(MAX_CONNECTIONS + 1)) - $signed(RES_W'(open_r)))
                    * $signed(RES_W'(QUEUE_PRIORITIES)));
  assign head_ok  = head < LINK_NONE;
  assign grant_ok = (newc_r || (left >= reserve)) && head_ok;
  assign free_ok  = pres_r && (LINK_W'(idx_r) < LINK_NONE);

  always_comb begin
    head_next  = head;
    count_next = count;
    we         = 1'b0;
    waddr      = head[IDX_W-1:0];
    wdata      = LINK_NONE;
    grant_next = 1'b0;
    gidx_next  = '0;
    case (op_r)
      OP_ALLOC: begin
        if (grant_ok) begin
          grant_next = 1'b1;
          gidx_next  = CHUNK_W'(head);
          head_next  = link;
          we         = 1'b1;
          if (count != '0) begin
            count_next = count - COUNT_W'(1);
          end
        end
      end
      OP_FREE: begin
        if (free_ok) begin
          we        = 1'b1;
          waddr     = IDX_W'(idx_r);
          wdata     = head;
          head_next = LINK_W'(idx_r);
          if (count < COUNT_W'(POOL_CHUNKS)) begin
            count_next = count + COUNT_W'(1);
          end
        end
      end
      OP_QUERY: begin
        grant_next = grant_ok;
      end
      default: begin
        grant_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op;
      newc_r <= new_connection;
      pres_r <= chunk_present;
      idx_r  <= chunk_index;
      need_r <= chunks_needed;
      open_r <= open_connections;
      rd_vld <= vld[head[IDX_W-1:0]];
    end
    if (cmd.execute) begin
      granted       <= grant_next;
      granted_index <= gidx_next;
      free_count    <= FCOUNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= COUNT_W'(POOL_CHUNKS);
      vld   <= '0;
    end else if (cmd.execute) begin
      head  <= head_next;
      count <= count_next;
      if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rfla_checker.sv -----
module rfla_checker
  import rfla_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic                granted,
  input logic [CHUNK_W-1:0]  granted_index,
  input logic [FCOUNT_W-1:0] free_count
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one was in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted)
      && $stable(granted_index) && $stable(free_count))
    else $error("stalled response changed");

  a_refused_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !granted |-> granted_index == '0)
    else $error("refused response carries a chunk index");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> free_count <= FCOUNT_W'(POOL_CHUNKS))
    else $error("free count above pool size");

endmodule

bind reserved_free_list_allocator rfla_checker u_rfla_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .granted      (rsp.granted),
  .granted_index(rsp.granted_index),
  .free_count   (rsp.free_count)
);

// ----- sim/rfla_pool_checker.sv -----
module rfla_pool_checker
  import rfla_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rfla_req_if  req,
  rfla_rsp_if  rsp,
  input  logic closing,
  output int   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                granted;
    logic [CHUNK_W-1:0]  index;
    logic [FCOUNT_W-1:0] count;
  } pool_result_t;

  logic [LINK_W-1:0]  link_mem [POOL_CHUNKS];
  logic [LINK_W-1:0]  head;
  logic [COUNT_W-1:0] free_left;
  pool_result_t       pending_results [$];
  logic               closed;

  task automatic report(string what, int got, int want);
    $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic grant_allowed(logic bypass, int asked, int open_conn);
    int headroom;
    int reserve;
    headroom = int'(free_left) - asked;
    reserve  = (MAX_CONNECTIONS + 1 - open_conn) * QUEUE_PRIORITIES;
    if (!bypass && headroom < reserve) return 1'b0;
    return head < LINK_NONE;
  endfunction

  task automatic apply_request(output pool_result_t res);
    int slot;
    res = '0;
    case (req.op)
      OP_ALLOC: begin
        if (grant_allowed(req.new_connection, 1, int'(req.open_connections))) begin
          res.granted = 1'b1;
          res.index   = head[IDX_W-1:0];
          slot        = int'(head);
          head        = link_mem[slot];
          link_mem[slot] = LINK_NONE;
          if (free_left > 0) free_left--;
        end
      end
      OP_FREE: begin
        if (req.chunk_present && int'(req.chunk_index) < POOL_CHUNKS) begin
          link_mem[req.chunk_index] = head;
          head = LINK_W'(req.chunk_index);
          if (free_left < POOL_CHUNKS) free_left++;
        end
      end
      OP_QUERY: begin
        res.granted = grant_allowed(req.new_connection, int'(req.chunks_needed),
                                    int'(req.open_connections));
      end
      default: begin
      end
    endcase
    res.count = free_left;
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t fresh;
    if (rst) begin
      for (int i = 0; i < POOL_CHUNKS; i++) link_mem[i] = LINK_W'(i + 1);
      head       = '0;
      free_left  = COUNT_W'(POOL_CHUNKS);
      mismatches = 0;
      closed     = 1'b0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report("response transaction with nothing outstanding", int'(rsp.free_count), 0);
        end else begin
          want = pending_results.pop_front();
          if (rsp.granted !== want.granted)
            report("granted", int'(rsp.granted), int'(want.granted));
          if (rsp.granted_index !== want.index)
            report("granted_index", int'(rsp.granted_index), int'(want.index));
          if (rsp.free_count !== want.count)
            report("free_count", int'(rsp.free_count), int'(want.count));
        end
      end
      if (req.valid && req.ready) begin
        apply_request(fresh);
        pending_results.push_back(fresh);
      end
      if (closing && !closed) begin
        if (pending_results.size() != 0)
          report("responses never returned", 0, pending_results.size());
        closed = 1'b1;
      end
    end
  end

endmodule

// ----- sim/reserved_free_list_allocator_test.sv -----
module reserved_free_list_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfla_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int MAX_GAP        = 15;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PAUSE_SEGMENT  = 12;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic               new_connection;
    logic               chunk_present;
    logic [CHUNK_W-1:0] chunk_index;
    logic [NEED_W-1:0]  chunks_needed;
    logic [OPEN_W-1:0]  open_connections;
  } request_t;

  typedef enum {MIX_DRAIN, MIX_FILL, MIX_BALANCED, MIX_RESERVE} mix_t;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic closing = 1'b0;
  logic calm    = 1'b0;
  int   mismatches;
  int   items_sent = 0;
  int   last_free_count = POOL_CHUNKS;

  logic [OP_W-1:0]    ops_in_flight [$];
  logic [CHUNK_W-1:0] held_chunks [$];

  rfla_req_if req ();
  rfla_rsp_if rsp ();

  reserved_free_list_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rfla_pool_checker pool_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .closing    (closing),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Chunks granted by the block are kept so that most frees return a chunk in use.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) ops_in_flight.push_back(req.op);
      if (rsp.valid && rsp.ready && ops_in_flight.size() != 0) begin
        if (ops_in_flight.pop_front() == OP_ALLOC && rsp.granted)
          held_chunks.push_back(rsp.granted_index);
        last_free_count = int'(rsp.free_count);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("reserved_free_list_allocator verification failed");
    $finish;
  end

  initial begin : receiver
    int stall;
    rsp.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  task automatic send_request(input request_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid            <= 1'b1;
    req.op               <= r.op;
    req.new_connection   <= r.new_connection;
    req.chunk_present    <= r.chunk_present;
    req.chunk_index      <= r.chunk_index;
    req.chunks_needed    <= r.chunks_needed;
    req.open_connections <= r.open_connections;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_directed(input logic [OP_W-1:0] op, input logic bypass,
                               input logic present, input int index, input int needed,
                               input int open_conn);
    request_t r;
    r.op               = op;
    r.new_connection   = bypass;
    r.chunk_present    = present;
    r.chunk_index      = CHUNK_W'(index);
    r.chunks_needed    = NEED_W'(needed);
    r.open_connections = OPEN_W'(open_conn);
    send_request(r);
  endtask

  task automatic idle_request_side();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic draw_request(input mix_t mix, output request_t r);
    int roll;
    int k;
    int reserve;
    int target;
    roll = $urandom_range(0, 99);
    r.new_connection   = ($urandom_range(0, 9) < ((mix == MIX_DRAIN) ? 7 : 3));
    r.open_connections = OPEN_W'($urandom_range(0, 7));
    r.chunk_present    = 1'($urandom_range(0, 1));
    r.chunk_index      = CHUNK_W'($urandom_range(0, POOL_CHUNKS - 1));
    r.chunks_needed    = NEED_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, POOL_CHUNKS));
    case (mix)
      MIX_DRAIN: begin
        r.op = (roll < 80) ? OP_ALLOC : (roll < 90) ? OP_QUERY :
               (roll < 98) ? OP_FREE : OP_SPARE;
      end
      MIX_FILL: begin
        r.op = (roll < 15) ? OP_ALLOC : (roll < 25) ? OP_QUERY :
               (roll < 98) ? OP_FREE : OP_SPARE;
      end
      MIX_BALANCED: begin
        r.op = (roll < 35) ? OP_ALLOC : (roll < 65) ? OP_FREE :
               (roll < 95) ? OP_QUERY : OP_SPARE;
      end
      default: begin
        r.op = (roll < 45) ? OP_ALLOC : (roll < 90) ? OP_QUERY :
               (roll < 97) ? OP_FREE : OP_SPARE;
        r.new_connection = ($urandom_range(0, 9) == 0);
        // Aim the query just either side of the reserve boundary.
        reserve = (MAX_CONNECTIONS + 1 - int'(r.open_connections)) * QUEUE_PRIORITIES;
        target  = last_free_count - reserve + int'($urandom_range(0, 4)) - 2;
        if (target < 0) target = 0;
        if (target > 127) target = 127;
        r.chunks_needed = NEED_W'(target);
      end
    endcase
    if (r.op == OP_FREE) begin
      r.chunk_present = ($urandom_range(0, 9) != 0);
      if (r.chunk_present && held_chunks.size() != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, held_chunks.size() - 1);
        r.chunk_index = held_chunks[k];
        held_chunks.delete(k);
      end
    end
  endtask

  initial begin : stimulus
    mix_t     mix;
    int       span;
    int       segment;
    request_t r;
    req.valid            = 1'b0;
    req.op               = OP_ALLOC;
    req.new_connection   = 1'b0;
    req.chunk_present    = 1'b0;
    req.chunk_index      = '0;
    req.chunks_needed    = '0;
    req.open_connections = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_directed(OP_QUERY, 1'b0, 1'b0, 0, 0, 0);
    send_directed(OP_QUERY, 1'b0, 1'b0, 0, 44, 0);
    send_directed(OP_QUERY, 1'b0, 1'b0, 0, 45, 0);
    send_directed(OP_QUERY, 1'b1, 1'b0, 0, 127, 0);
    send_directed(OP_QUERY, 1'b0, 1'b0, 0, 127, 7);
    send_directed(OP_QUERY, 1'b0, 1'b0, 0, 64, 6);
    send_directed(OP_QUERY, 1'b0, 1'b1, 63, 0, 5);
    send_directed(OP_SPARE, 1'b1, 1'b1, 63, 127, 7);
    send_directed(OP_FREE, 1'b0, 1'b0, 63, 0, 0);
    send_directed(OP_ALLOC, 1'b0, 1'b0, 0, 127, 0);
    send_directed(OP_ALLOC, 1'b1, 1'b1, 63, 0, 7);
    send_directed(OP_ALLOC, 1'b0, 1'b0, 0, 0, 5);
    send_directed(OP_FREE, 1'b0, 1'b1, 0, 0, 0);
    send_directed(OP_FREE, 1'b1, 1'b1, 1, 127, 7);
    send_directed(OP_FREE, 1'b0, 1'b1, 2, 0, 0);
    send_directed(OP_FREE, 1'b0, 1'b1, 63, 0, 0);
    send_directed(OP_ALLOC, 1'b1, 1'b0, 0, 0, 0);
    send_directed(OP_QUERY, 1'b0, 1'b0, 0, 43, 0);

    items_sent = 0;
    segment    = 0;
    while (items_sent < RANDOM_ITEMS) begin
      mix  = mix_t'($urandom_range(0, 3));
      calm = ($urandom_range(0, 4) == 0);
      span = $urandom_range(20, 80);
      if (segment == PAUSE_SEGMENT) begin
        idle_request_side();
        while (ops_in_flight.size() != 0) @(posedge clk);
      end
      repeat (span) begin
        draw_request(mix, r);
        send_request(r);
      end
      segment++;
    end
    calm = 1'b0;

    idle_request_side();
    while (ops_in_flight.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    closing <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("reserved_free_list_allocator verification clean");
    end else begin
      $display("reserved_free_list_allocator verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rfla_pkg.sv
hw/rtl/rfla_if.sv
hw/rtl/rfla_ram.sv
hw/rtl/rfla_ctrl.sv
hw/rtl/rfla_dp.sv
hw/rtl/reserved_free_list_allocator.sv
hw/rtl/rfla_checker.sv
sim/rfla_pool_checker.sv
sim/reserved_free_list_allocator_test.sv
